// ===== hdl/rmq_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rmq_pkg
// Shared types and constants for the rotation matrix to quaternion core.
// ----------------------------------------------------------------------------
package rmq_pkg;

    localparam int ELEM_W    = 16;             // Q2.14 element and result
    localparam int DIFF_W    = 17;             // raw sum or difference of two elements
    localparam int RAD_W     = 17;             // clamped radicand, Q.14
    localparam int RAD_SHIFT = 28;             // radicand scaled to give a Q.21 root
    localparam int V_W       = 46;             // even width holding RAD_W + RAD_SHIFT
    localparam int ROOT_W    = V_W / 2;        // root bits, one per sqrt stage
    localparam int REM_W     = ROOT_W + 3;     // sqrt partial remainder
    localparam int NUM_SHIFT = 20;
    localparam int NUM_W     = DIFF_W + NUM_SHIFT + 1;
    localparam int QUO_W     = 24;             // quotient bits, one per divide stage
    localparam int FIFO_DEPTH = 4;
    localparam int FIFO_AW    = $clog2(FIFO_DEPTH);

    // slot of the component that is s/2 rather than a scaled term
    typedef enum logic [1:0] {
        HALF_X = 2'd0,
        HALF_Y = 2'd1,
        HALF_Z = 2'd2,
        HALF_W = 2'd3
    } t_half;

    // classified item: the three scaled terms go to the remaining slots in x, y, z, w order
    typedef struct packed {
        logic [RAD_W-1:0]         rad;
        logic signed [DIFF_W-1:0] d_a;
        logic signed [DIFF_W-1:0] d_b;
        logic signed [DIFF_W-1:0] d_c;
        t_half                    half;
    } t_item;

    typedef struct packed {
        logic [ROOT_W-1:0] root;
        logic              neg_a;
        logic              neg_b;
        logic              neg_c;
        t_half             half;
    } t_dside;

endpackage

// ===== hdl/rmq_front.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rmq_front
// Accepts a matrix, picks the branch and pivot, and forms radicand and terms.
// ----------------------------------------------------------------------------
module rmq_front (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              push,
    output logic                              full,
    input  logic signed [rmq_pkg::ELEM_W-1:0] i_m00,
    input  logic signed [rmq_pkg::ELEM_W-1:0] i_m01,
    input  logic signed [rmq_pkg::ELEM_W-1:0] i_m02,
    input  logic signed [rmq_pkg::ELEM_W-1:0] i_m10,
    input  logic signed [rmq_pkg::ELEM_W-1:0] i_m11,
    input  logic signed [rmq_pkg::ELEM_W-1:0] i_m12,
    input  logic signed [rmq_pkg::ELEM_W-1:0] i_m20,
    input  logic signed [rmq_pkg::ELEM_W-1:0] i_m21,
    input  logic signed [rmq_pkg::ELEM_W-1:0] i_m22,
    output logic                              o_vld,
    input  logic                              i_rdy,
    output rmq_pkg::t_item                    o_item
);
    import rmq_pkg::*;

    logic               r_vld;
    t_item              r_item;
    t_item              n_item;
    logic signed [18:0] trace;
    logic signed [18:0] rad;
    logic [1:0]         piv;
    logic               take;

    assign take = push && !full;
    assign full = r_vld && !i_rdy;

    always_comb begin
        trace = 19'(i_m00) + 19'(i_m11) + 19'(i_m22);
        piv = 2'd0;
        if (i_m11 > i_m00) begin
            piv = 2'd1;
        end
        if (i_m22 > ((piv == 2'd1) ? i_m11 : i_m00)) begin
            piv = 2'd2;
        end
        n_item.half = HALF_W;
        n_item.d_a  = 17'(i_m12) - 17'(i_m21);
        n_item.d_b  = 17'(i_m20) - 17'(i_m02);
        n_item.d_c  = 17'(i_m01) - 17'(i_m10);
        rad = 19'sd16384 + trace;
        if (trace <= 0) begin
            case (piv)
                2'd0: begin
                    rad = 19'sd16384 + 19'(i_m00) - (19'(i_m11) + 19'(i_m22));
                    n_item.half = HALF_X;
                    n_item.d_a  = 17'(i_m01) + 17'(i_m10);
                    n_item.d_b  = 17'(i_m02) + 17'(i_m20);
                    n_item.d_c  = 17'(i_m12) - 17'(i_m21);
                end
                2'd1: begin
                    rad = 19'sd16384 + 19'(i_m11) - (19'(i_m22) + 19'(i_m00));
                    n_item.half = HALF_Y;
                    n_item.d_a  = 17'(i_m10) + 17'(i_m01);
                    n_item.d_b  = 17'(i_m12) + 17'(i_m21);
                    n_item.d_c  = 17'(i_m20) - 17'(i_m02);
                end
                default: begin
                    rad = 19'sd16384 + 19'(i_m22) - (19'(i_m00) + 19'(i_m11));
                    n_item.half = HALF_Z;
                    n_item.d_a  = 17'(i_m20) + 17'(i_m02);
                    n_item.d_b  = 17'(i_m21) + 17'(i_m12);
                    n_item.d_c  = 17'(i_m01) - 17'(i_m10);
                end
            endcase
        end
        // negative radicand clamps to zero
        n_item.rad = (rad <= 0) ? '0 : rad[RAD_W-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
        end else if (take) begin
            r_vld <= 1'b1;
        end else if (i_rdy) begin
            r_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (take) begin
            r_item <= n_item;
        end
    end

    assign o_vld  = r_vld;
    assign o_item = r_item;

endmodule

// ===== hdl/rmq_fifo.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rmq_fifo
// Short queue of classified items between the front and back parts.
// ----------------------------------------------------------------------------
module rmq_fifo (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_wr,
    input  rmq_pkg::t_item i_item,
    output logic           o_full,
    input  logic           i_rd,
    output logic           o_empty,
    output rmq_pkg::t_item o_item
);
    import rmq_pkg::*;

    t_item              r_mem [FIFO_DEPTH];
    logic [FIFO_AW-1:0] r_wp;
    logic [FIFO_AW-1:0] r_rp;
    logic [FIFO_AW:0]   r_cnt;
    logic               wr_ok;
    logic               rd_ok;

    assign o_full  = (r_cnt == (FIFO_AW+1)'(FIFO_DEPTH));
    assign o_empty = (r_cnt == '0);
    assign wr_ok   = i_wr && !o_full;
    assign rd_ok   = i_rd && !o_empty;
    assign o_item  = r_mem[r_rp];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (wr_ok) begin
                r_wp <= r_wp + 1'b1;
            end
            if (rd_ok) begin
                r_rp <= r_rp + 1'b1;
            end
            if (wr_ok && !rd_ok) begin
                r_cnt <= r_cnt + 1'b1;
            end else if (rd_ok && !wr_ok) begin
                r_cnt <= r_cnt - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (wr_ok) begin
            r_mem[r_wp] <= i_item;
        end
    end

endmodule

// ===== hdl/rmq_sqrt.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rmq_sqrt
// Pipelined integer square root of rad * 2^28, one root bit per stage.
// ----------------------------------------------------------------------------
module rmq_sqrt (
    input  logic                        i_clk,
    input  logic                        i_en,
    input  logic [rmq_pkg::RAD_W-1:0]   i_rad,
    output logic [rmq_pkg::ROOT_W-1:0]  o_root
);
    import rmq_pkg::*;

    logic [V_W-1:0]    r_v [ROOT_W];
    logic [ROOT_W-1:0] r_r [ROOT_W];
    logic [REM_W-1:0]  r_m [ROOT_W];

    for (genvar k = 0; k < ROOT_W; k++) begin : g_stage
        logic [V_W-1:0]    v_in;
        logic [ROOT_W-1:0] r_in;
        logic [REM_W-1:0]  m_in;
        logic [REM_W-1:0]  rem_t;
        logic [REM_W-1:0]  trial;

        if (k == 0) begin : g_first
            assign v_in = V_W'({i_rad, {RAD_SHIFT{1'b0}}});
            assign r_in = '0;
            assign m_in = '0;
        end else begin : g_next
            assign v_in = r_v[k-1];
            assign r_in = r_r[k-1];
            assign m_in = r_m[k-1];
        end

        assign rem_t = {m_in[REM_W-3:0], v_in[V_W-1 -: 2]};
        assign trial = REM_W'({r_in, 2'b01});

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_v[k] <= {v_in[V_W-3:0], 2'b00};
                if (rem_t >= trial) begin
                    r_m[k] <= rem_t - trial;
                    r_r[k] <= {r_in[ROOT_W-2:0], 1'b1};
                end else begin
                    r_m[k] <= rem_t;
                    r_r[k] <= {r_in[ROOT_W-2:0], 1'b0};
                end
            end
        end
    end

    assign o_root = r_r[ROOT_W-1];

endmodule

// ===== hdl/rmq_div.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rmq_div
// Pipelined restoring divider, one quotient bit per stage.
// ----------------------------------------------------------------------------
module rmq_div (
    input  logic                        i_clk,
    input  logic                        i_en,
    input  logic [rmq_pkg::NUM_W-1:0]   i_num,
    input  logic [rmq_pkg::ROOT_W-1:0]  i_den,
    output logic [rmq_pkg::QUO_W-1:0]   o_quo
);
    import rmq_pkg::*;

    localparam int CMP_W = NUM_W + ROOT_W;

    logic [NUM_W-1:0]  r_rem [QUO_W];
    logic [ROOT_W-1:0] r_den [QUO_W];
    logic [QUO_W-1:0]  r_quo [QUO_W];

    for (genvar t = 0; t < QUO_W; t++) begin : g_stage
        logic [NUM_W-1:0]  rem_in;
        logic [ROOT_W-1:0] den_in;
        logic [QUO_W-1:0]  quo_in;
        logic [CMP_W-1:0]  sh;

        if (t == 0) begin : g_first
            assign rem_in = i_num;
            assign den_in = i_den;
            assign quo_in = '0;
        end else begin : g_next
            assign rem_in = r_rem[t-1];
            assign den_in = r_den[t-1];
            assign quo_in = r_quo[t-1];
        end

        assign sh = CMP_W'(den_in) << (QUO_W - 1 - t);

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_den[t] <= den_in;
                if (CMP_W'(rem_in) >= sh) begin
                    r_rem[t] <= rem_in - sh[NUM_W-1:0];
                    r_quo[t] <= quo_in | (QUO_W'(1) << (QUO_W - 1 - t));
                end else begin
                    r_rem[t] <= rem_in;
                    r_quo[t] <= quo_in;
                end
            end
        end
    end

    assign o_quo = r_quo[QUO_W-1];

endmodule

// ===== hdl/rmq_back.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rmq_back
// Square root, three dividers and output rounding/saturation with result register.
// ----------------------------------------------------------------------------
module rmq_back (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_vld,
    output logic                               o_rd,
    input  rmq_pkg::t_item                     i_item,
    output logic                               empty,
    input  logic                               pop,
    output logic signed [rmq_pkg::ELEM_W-1:0]  o_quat_x,
    output logic signed [rmq_pkg::ELEM_W-1:0]  o_quat_y,
    output logic signed [rmq_pkg::ELEM_W-1:0]  o_quat_z,
    output logic signed [rmq_pkg::ELEM_W-1:0]  o_quat_w
);
    import rmq_pkg::*;

    logic              en;
    logic              r_sv [ROOT_W];
    t_item             r_sside [ROOT_W];
    logic              r_dv [QUO_W];
    t_dside            r_dside [QUO_W];
    logic [ROOT_W-1:0] root;
    t_item             sq_item;
    t_dside            n_dside;
    logic [NUM_W-1:0]  num_a, num_b, num_c;
    logic [QUO_W-1:0]  quo_a, quo_b, quo_c;
    t_dside            dv;
    logic [QUO_W:0]    half_raw;
    logic signed [ELEM_W-1:0] half_v, v_a, v_b, v_c;
    logic              r_out_vld;
    logic signed [ELEM_W-1:0] r_qx, r_qy, r_qz, r_qw;

    function automatic logic [NUM_W-1:0] mk_num(logic signed [DIFF_W-1:0] d,
                                                logic [ROOT_W-1:0] s);
        logic [DIFF_W-1:0] mag;
        mag = d[DIFF_W-1] ? DIFF_W'(-d) : DIFF_W'(d);
        return {1'b0, mag, {NUM_SHIFT{1'b0}}} + NUM_W'(s >> 1);
    endfunction

    function automatic logic signed [ELEM_W-1:0] fin(logic [QUO_W-1:0] q, logic neg,
                                                     logic zero);
        logic signed [ELEM_W-1:0] r;
        if (zero) begin
            r = '0;
        end else if (neg) begin
            r = (q >= QUO_W'(32768)) ? ELEM_W'(-32768) : -$signed(q[ELEM_W-1:0]);
        end else begin
            r = (q > QUO_W'(32767)) ? ELEM_W'(32767) : $signed(q[ELEM_W-1:0]);
        end
        return r;
    endfunction

    // whole back pipeline moves unless the result register is held
    assign en    = !r_out_vld || pop;
    assign o_rd  = en;
    assign empty = !r_out_vld;

    rmq_sqrt u_sqrt (
        .i_clk  (i_clk),
        .i_en   (en),
        .i_rad  (i_item.rad),
        .o_root (root)
    );

    assign sq_item = r_sside[ROOT_W-1];
    assign num_a   = mk_num(sq_item.d_a, root);
    assign num_b   = mk_num(sq_item.d_b, root);
    assign num_c   = mk_num(sq_item.d_c, root);

    always_comb begin
        n_dside.root  = root;
        n_dside.neg_a = sq_item.d_a[DIFF_W-1];
        n_dside.neg_b = sq_item.d_b[DIFF_W-1];
        n_dside.neg_c = sq_item.d_c[DIFF_W-1];
        n_dside.half  = sq_item.half;
    end

    rmq_div u_div_a (.i_clk(i_clk), .i_en(en), .i_num(num_a), .i_den(root), .o_quo(quo_a));
    rmq_div u_div_b (.i_clk(i_clk), .i_en(en), .i_num(num_b), .i_den(root), .o_quo(quo_b));
    rmq_div u_div_c (.i_clk(i_clk), .i_en(en), .i_num(num_c), .i_den(root), .o_quo(quo_c));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < ROOT_W; k++) begin
                r_sv[k] <= 1'b0;
            end
            for (int k = 0; k < QUO_W; k++) begin
                r_dv[k] <= 1'b0;
            end
        end else if (en) begin
            r_sv[0] <= i_vld;
            for (int k = 1; k < ROOT_W; k++) begin
                r_sv[k] <= r_sv[k-1];
            end
            r_dv[0] <= r_sv[ROOT_W-1];
            for (int k = 1; k < QUO_W; k++) begin
                r_dv[k] <= r_dv[k-1];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_sside[0] <= i_item;
            for (int k = 1; k < ROOT_W; k++) begin
                r_sside[k] <= r_sside[k-1];
            end
            r_dside[0] <= n_dside;
            for (int k = 1; k < QUO_W; k++) begin
                r_dside[k] <= r_dside[k-1];
            end
        end
    end

    assign dv       = r_dside[QUO_W-1];
    assign half_raw = (QUO_W+1)'(dv.root) + (QUO_W+1)'(128);
    assign half_v   = (half_raw[QUO_W:8] > (QUO_W-7)'(32767)) ? ELEM_W'(32767)
                                                             : $signed(half_raw[8 +: ELEM_W]);
    assign v_a = fin(quo_a, dv.neg_a, dv.root == '0);
    assign v_b = fin(quo_b, dv.neg_b, dv.root == '0);
    assign v_c = fin(quo_c, dv.neg_c, dv.root == '0);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (en) begin
            r_out_vld <= r_dv[QUO_W-1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            case (dv.half)
                HALF_X: begin
                    r_qx <= half_v; r_qy <= v_a; r_qz <= v_b; r_qw <= v_c;
                end
                HALF_Y: begin
                    r_qx <= v_a; r_qy <= half_v; r_qz <= v_b; r_qw <= v_c;
                end
                HALF_Z: begin
                    r_qx <= v_a; r_qy <= v_b; r_qz <= half_v; r_qw <= v_c;
                end
                default: begin
                    r_qx <= v_a; r_qy <= v_b; r_qz <= v_c; r_qw <= half_v;
                end
            endcase
        end
    end

    assign o_quat_x = r_qx;
    assign o_quat_y = r_qy;
    assign o_quat_z = r_qz;
    assign o_quat_w = r_qw;

endmodule

// ===== hdl/rotation_matrix_to_quaternion_core.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rotation_matrix_to_quaternion_core
// Converts a Q2.14 3x3 rotation matrix to a saturated Q2.14 quaternion.
// ----------------------------------------------------------------------------
// Usage:
//   Input side is a queue write port: a matrix transfers on a clock edge with
//   push high and full low. Results come out as a queue read port: the oldest
//   quaternion is on o_quat_* while empty is low and transfers on pop.
//   Throughput: one matrix per cycle, sustained while results are popped.
//   Path from input transfer to empty going low with an idle queue: the
//   classify register loads on the transfer edge, then 1 queue write,
//   23 square-root stages, 24 divider stages, 1 result register. The square
//   root and the three dividers are bit-per-stage pipelines.
//   With pop held off and a result waiting, the back pipeline freezes, the
//   4-entry queue fills, and full rises once the classify register is also held.
//   Reset (synchronous, active low) empties all stages and the queue; no
//   clearing pass is needed.
// ----------------------------------------------------------------------------
module rotation_matrix_to_quaternion_core (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              push,
    output logic                              full,
    input  logic signed [rmq_pkg::ELEM_W-1:0] i_m00,
    input  logic signed [rmq_pkg::ELEM_W-1:0] i_m01,
    input  logic signed [rmq_pkg::ELEM_W-1:0] i_m02,
    input  logic signed [rmq_pkg::ELEM_W-1:0] i_m10,
    input  logic signed [rmq_pkg::ELEM_W-1:0] i_m11,
    input  logic signed [rmq_pkg::ELEM_W-1:0] i_m12,
    input  logic signed [rmq_pkg::ELEM_W-1:0] i_m20,
    input  logic signed [rmq_pkg::ELEM_W-1:0] i_m21,
    input  logic signed [rmq_pkg::ELEM_W-1:0] i_m22,
    output logic                              empty,
    input  logic                              pop,
    output logic signed [rmq_pkg::ELEM_W-1:0] o_quat_x,
    output logic signed [rmq_pkg::ELEM_W-1:0] o_quat_y,
    output logic signed [rmq_pkg::ELEM_W-1:0] o_quat_z,
    output logic signed [rmq_pkg::ELEM_W-1:0] o_quat_w
);
    import rmq_pkg::*;

    logic  f_vld;
    t_item f_item;
    logic  q_full;
    logic  q_empty;
    t_item q_item;
    logic  b_rd;

    rmq_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .push    (push),
        .full    (full),
        .i_m00   (i_m00),
        .i_m01   (i_m01),
        .i_m02   (i_m02),
        .i_m10   (i_m10),
        .i_m11   (i_m11),
        .i_m12   (i_m12),
        .i_m20   (i_m20),
        .i_m21   (i_m21),
        .i_m22   (i_m22),
        .o_vld   (f_vld),
        .i_rdy   (!q_full),
        .o_item  (f_item)
    );

    rmq_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_wr    (f_vld),
        .i_item  (f_item),
        .o_full  (q_full),
        .i_rd    (b_rd),
        .o_empty (q_empty),
        .o_item  (q_item)
    );

    rmq_back u_back (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_vld    (!q_empty),
        .o_rd     (b_rd),
        .i_item   (q_item),
        .empty    (empty),
        .pop      (pop),
        .o_quat_x (o_quat_x),
        .o_quat_y (o_quat_y),
        .o_quat_z (o_quat_z),
        .o_quat_w (o_quat_w)
    );

endmodule

// ===== sim/tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for rotation_matrix_to_quaternion_core.
// Directed corner matrices, then random rotation-like and raw matrices, are
// pushed with random gaps and popped with random stalls. Every popped
// quaternion is compared against a bit-exact fixed-point predictor.
// ----------------------------------------------------------------------------
module tb;

    localparam int ELEM_W = rmq_pkg::ELEM_W;
    localparam int CYCLE_LIMIT = 400000;

    typedef logic signed [ELEM_W-1:0] t_elem;
    typedef struct packed {
        t_elem x;
        t_elem y;
        t_elem z;
        t_elem w;
    } t_quat;

    logic  i_clk = 1'b0;
    logic  i_rst_n = 1'b0;
    logic  push = 1'b0;
    logic  pop = 1'b0;
    logic  full;
    logic  empty;
    t_elem i_m00 = '0, i_m01 = '0, i_m02 = '0;
    t_elem i_m10 = '0, i_m11 = '0, i_m12 = '0;
    t_elem i_m20 = '0, i_m21 = '0, i_m22 = '0;
    t_elem o_quat_x, o_quat_y, o_quat_z, o_quat_w;

    t_quat quat_fifo[$];
    int    err_cnt = 0;
    int    cycle_cnt = 0;
    bit    stim_done = 1'b0;

    rotation_matrix_to_quaternion_core dut (.*);

    always #1 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt > CYCLE_LIMIT) begin
            $display("status: fail");
            $finish;
        end
    end

    // ---------------- predictor ----------------
    function automatic longint sat_q(longint v);
        if (v > 32767) return 32767;
        if (v < -32768) return -32768;
        return v;
    endfunction

    function automatic longint root_q21(longint rad);
        longint unsigned v, r, b;
        if (rad <= 0) return 0;
        v = longint'(rad) << 28;
        r = 0;
        b = 64'd1 << 62;
        while (b > v) b >>= 2;
        while (b != 0) begin
            if (v >= r + b) begin
                v -= r + b;
                r = (r >> 1) + b;
            end else begin
                r >>= 1;
            end
            b >>= 2;
        end
        return r;
    endfunction

    function automatic longint inv_scale(longint d, longint s);
        longint mag, q;
        if (s == 0) return 0;
        mag = (d < 0) ? -d : d;
        q = ((mag << 20) + (s >> 1)) / s;
        if (q > 65536) q = 65536;
        return sat_q((d < 0) ? -q : q);
    endfunction

    function automatic t_quat matrix_to_quat(t_elem e[9]);
        longint m[3][3];
        longint q[4];
        longint s;
        int a, b, c;
        for (int r = 0; r < 3; r++)
            for (int k = 0; k < 3; k++)
                m[r][k] = e[r*3+k];
        if (m[0][0] + m[1][1] + m[2][2] > 0) begin
            s = root_q21(16384 + m[0][0] + m[1][1] + m[2][2]);
            q[3] = sat_q((s + 128) >>> 8);
            q[0] = inv_scale(m[1][2] - m[2][1], s);
            q[1] = inv_scale(m[2][0] - m[0][2], s);
            q[2] = inv_scale(m[0][1] - m[1][0], s);
        end else begin
            a = 0;
            if (m[1][1] > m[0][0]) a = 1;
            if (m[2][2] > m[a][a]) a = 2;
            b = (a + 1) % 3;
            c = (b + 1) % 3;
            s = root_q21(16384 + m[a][a] - (m[b][b] + m[c][c]));
            q[a] = sat_q((s + 128) >>> 8);
            q[3] = inv_scale(m[b][c] - m[c][b], s);
            q[b] = inv_scale(m[a][b] + m[b][a], s);
            q[c] = inv_scale(m[a][c] + m[c][a], s);
        end
        return '{x: t_elem'(q[0]), y: t_elem'(q[1]), z: t_elem'(q[2]), w: t_elem'(q[3])};
    endfunction

    // ---------------- sender ----------------
    task automatic send_matrix(t_elem e[9], bit no_gap = 1'b0);
        int gap;
        gap = no_gap ? 0 : $urandom_range(0, 9);
        if (gap != 0 && $urandom_range(0, 3) == 0) gap = 0;
        if (gap != 0) begin
            push <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        {i_m00, i_m01, i_m02, i_m10, i_m11, i_m12, i_m20, i_m21, i_m22}
            <= {e[0], e[1], e[2], e[3], e[4], e[5], e[6], e[7], e[8]};
        push <= 1'b1;
        @(posedge i_clk);
        while (full) @(posedge i_clk);
        quat_fifo.push_back(matrix_to_quat(e));
    endtask

    function automatic t_elem rand_elem();
        return t_elem'($urandom);
    endfunction

    // ---------------- checker ----------------
    initial begin : pop_side
        t_quat want;
        int    stall;
        wait (i_rst_n === 1'b1);
        forever begin
            stall = $urandom_range(0, 9);
            if ($urandom_range(0, 3) == 0 || stim_done) stall = 0;
            if (stall != 0) begin
                pop <= 1'b0;
                repeat (stall) @(posedge i_clk);
            end
            pop <= 1'b1;
            @(posedge i_clk);
            while (empty !== 1'b0) @(posedge i_clk);
            if (quat_fifo.size() == 0) begin
                $error("result with no pending matrix");
                err_cnt++;
            end else begin
                want = quat_fifo.pop_front();
                if (o_quat_x !== want.x) begin
                    $error("quat_x exp %0d got %0d", want.x, o_quat_x); err_cnt++;
                end
                if (o_quat_y !== want.y) begin
                    $error("quat_y exp %0d got %0d", want.y, o_quat_y); err_cnt++;
                end
                if (o_quat_z !== want.z) begin
                    $error("quat_z exp %0d got %0d", want.z, o_quat_z); err_cnt++;
                end
                if (o_quat_w !== want.w) begin
                    $error("quat_w exp %0d got %0d", want.w, o_quat_w); err_cnt++;
                end
            end
        end
    end

    // ---------------- tests ----------------
    task automatic test_directed();
        t_elem e[9];
        t_elem one = 16'sd16384;
        e = '{one, 0, 0, 0, one, 0, 0, 0, one};               send_matrix(e);
        e = '{one, 0, 0, 0, -one, 0, 0, 0, -one};             send_matrix(e);
        e = '{-one, 0, 0, 0, one, 0, 0, 0, -one};             send_matrix(e);
        e = '{-one, 0, 0, 0, -one, 0, 0, 0, one};             send_matrix(e);
        e = '{0, -one, 0, one, 0, 0, 0, 0, one};              send_matrix(e);
        e = '{0, 0, 0, 0, 0, 0, 0, 0, 0};                     send_matrix(e); // zero trace
        e = '{-one, 0, 0, 0, -one, 0, 0, 0, -one};            send_matrix(e); // tie
        e = '{-32768, 5, 7, 9, -32768, 11, 13, 15, -32768};   send_matrix(e); // most negative diagonal
        e = '{32767, 0, 0, 0, 32767, 0, 0, 0, 32767};         send_matrix(e);
        e = '{32767, 32767, 32767, -32768, 32767, 32767, -32768, -32768, 32767};
        send_matrix(e);
        e = '{-32768, 32767, -32768, 32767, -32768, 32767, -32768, 32767, -32768};
        send_matrix(e);
        e = '{-20000, 32767, 32767, 32767, -20000, 32767, 32767, 32767, -16385};
        send_matrix(e); // pivot on m22
        e = '{100, 0, 0, 0, 100, 0, 0, 0, -200};              send_matrix(e); // trace zero
        e = '{1, 0, 0, 0, 0, 0, 0, 0, 0};                     send_matrix(e); // trace one lsb
        e = '{-5, 1, 2, 3, -5, 4, 5, 6, -5};                  send_matrix(e);
        e = '{-7, 1, 2, 3, -3, 4, 5, 6, -3};                  send_matrix(e); // y/z tie
        e = '{-16384, 32767, -32768, -32768, -16384, 32767, 32767, -32768, -16384};
        send_matrix(e);
    endtask

    // random rotation-like: near-orthonormal, with random perturbation; some raw matrices too
    task automatic test_random(int n);
        t_elem e[9];
        real ax, ay, az, ang, c, s, t, nrm;
        for (int it = 0; it < n; it++) begin
            if ($urandom_range(0, 3) == 0) begin
                foreach (e[k]) e[k] = rand_elem();
            end else begin
                ax = real'($urandom_range(0, 2000)) - 1000.0;
                ay = real'($urandom_range(0, 2000)) - 1000.0;
                az = real'($urandom_range(0, 2000)) - 1000.0;
                nrm = $sqrt(ax*ax + ay*ay + az*az) + 1e-9;
                ax /= nrm; ay /= nrm; az /= nrm;
                ang = real'($urandom_range(0, 62832)) / 10000.0;
                c = $cos(ang); s = $sin(ang); t = 1.0 - c;
                e[0] = t_elem'(int'(16383.0 * (t*ax*ax + c)));
                e[1] = t_elem'(int'(16383.0 * (t*ax*ay - s*az)));
                e[2] = t_elem'(int'(16383.0 * (t*ax*az + s*ay)));
                e[3] = t_elem'(int'(16383.0 * (t*ax*ay + s*az)));
                e[4] = t_elem'(int'(16383.0 * (t*ay*ay + c)));
                e[5] = t_elem'(int'(16383.0 * (t*ay*az - s*ax)));
                e[6] = t_elem'(int'(16383.0 * (t*ax*az - s*ay)));
                e[7] = t_elem'(int'(16383.0 * (t*ay*az + s*ax)));
                e[8] = t_elem'(int'(16383.0 * (t*az*az + c)));
                if ($urandom_range(0, 4) == 0)
                    foreach (e[k]) e[k] = e[k] + t_elem'($urandom_range(0, 64) - 32);
            end
            send_matrix(e, it >= 600 && it < 700);   // back-to-back burst
        end
    endtask

    task automatic test_drain_pause();
        push <= 1'b0;
        while (quat_fifo.size() != 0) @(posedge i_clk);
    endtask

    initial begin
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_directed();
        test_drain_pause();
        test_random(1500);
        push <= 1'b0;
        stim_done = 1'b1;
        while (quat_fifo.size() != 0) @(posedge i_clk);
        repeat (60) @(posedge i_clk);
        if (err_cnt == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

endmodule
